// File: rtl/hrfs_pkg.sv
package hrfs_pkg;

    // Field limits
    localparam int METHOD_MAX  = 15;
    localparam int PATH_MAX    = 255;
    localparam int BODY_MAX    = 1023;
    localparam int REQUEST_MAX = 4095;

    // Counter widths follow from the limits; POS_W is set directly
    localparam int METHOD_W = $clog2(METHOD_MAX + 1);
    localparam int PATH_W   = $clog2(PATH_MAX + 1);
    localparam int BODY_W   = $clog2(BODY_MAX + 1);
    localparam int REQ_W    = $clog2(REQUEST_MAX + 1);
    localparam int POS_W    = 10;

    // Role codes
    localparam logic [1:0] ROLE_NONE   = 2'd0;
    localparam logic [1:0] ROLE_METHOD = 2'd1;
    localparam logic [1:0] ROLE_PATH   = 2'd2;
    localparam logic [1:0] ROLE_BODY   = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_request;
    } t_in_word;

    typedef struct packed {
        logic [7:0]       byte_out;
        logic [1:0]       role;
        logic [POS_W-1:0] field_position;
        logic             request_done;
        logic [3:0]       method_length;
        logic [7:0]       path_length;
        logic [9:0]       body_length;
    } t_out_word;

endpackage

// File: rtl/hrfs_stream_if.sv
interface hrfs_in_if import hrfs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hrfs_out_if import hrfs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/hrfs_tagger.sv
module hrfs_tagger import hrfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    output t_out_word o_word
);

    localparam logic [1:0] PH_METHOD = 2'd0;
    localparam logic [1:0] PH_PATH   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [2:0] MATCH_NONE  = 3'd0;
    localparam logic [2:0] MATCH_CR    = 3'd1;
    localparam logic [2:0] MATCH_CRLF  = 3'd2;
    localparam logic [2:0] MATCH_CRLFCR = 3'd3;
    localparam logic [2:0] MATCH_FOUND = 3'd4;

    logic [1:0]          r_phase, n_phase;
    logic [METHOD_W-1:0] r_method_cnt, n_method_cnt;
    logic [PATH_W-1:0]   r_path_cnt, n_path_cnt;
    logic [BODY_W-1:0]   r_body_cnt, n_body_cnt;
    logic [2:0]          r_match, n_match;
    logic                r_zero_seen, n_zero_seen;
    logic [REQ_W-1:0]    r_byte_cnt, n_byte_cnt;

    logic [7:0]       b;
    logic             is_method, is_path, is_body;
    logic [POS_W-1:0] pos;
    logic [1:0]       role;

    // Advance the CR LF CR LF matcher by one byte
    function automatic logic [2:0] next_match(input logic [2:0] st, input logic [7:0] c);
        logic [2:0] res;
        res = MATCH_NONE;
        if (c == CH_CR) begin
            res = (st == MATCH_CRLF) ? MATCH_CRLFCR : MATCH_CR;
        end else if (c == CH_LF) begin
            if (st == MATCH_CR) begin
                res = MATCH_CRLF;
            end else if (st == MATCH_CRLFCR) begin
                res = MATCH_FOUND;
            end
        end
        return res;
    endfunction

    always_comb begin
        b            = i_word.data_byte;
        n_phase      = r_phase;
        n_method_cnt = r_method_cnt;
        n_path_cnt   = r_path_cnt;
        n_body_cnt   = r_body_cnt;
        n_match      = r_match;
        n_zero_seen  = r_zero_seen;
        n_byte_cnt   = r_byte_cnt;
        is_method    = 1'b0;
        is_path      = 1'b0;
        is_body      = 1'b0;

        if (r_byte_cnt < REQ_W'(REQUEST_MAX)) begin
            unique case (r_phase)
                PH_METHOD: begin
                    if (b != CH_SPACE && r_method_cnt < METHOD_W'(METHOD_MAX)) begin
                        is_method    = 1'b1;
                        n_method_cnt = r_method_cnt + 1'b1;
                    end else begin
                        n_phase = PH_PATH;
                    end
                end
                PH_PATH: begin
                    if (b != CH_SPACE && b != CH_QUERY && b != CH_CR &&
                        r_path_cnt < PATH_W'(PATH_MAX)) begin
                        is_path    = 1'b1;
                        n_path_cnt = r_path_cnt + 1'b1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase

            if (r_match == MATCH_FOUND) begin
                if (r_body_cnt < BODY_W'(BODY_MAX)) begin
                    is_body    = 1'b1;
                    n_body_cnt = r_body_cnt + 1'b1;
                end
            end else if (!r_zero_seen) begin
                if (b == CH_NUL) begin
                    n_zero_seen = 1'b1;
                end else begin
                    n_match = next_match(r_match, b);
                end
            end

            n_byte_cnt = r_byte_cnt + 1'b1;
        end

        // Method wins over path, path over body
        role = ROLE_NONE;
        pos  = '0;
        if (is_method) begin
            role = ROLE_METHOD;
            pos  = POS_W'(r_method_cnt);
        end else if (is_path) begin
            role = ROLE_PATH;
            pos  = POS_W'(r_path_cnt);
        end else if (is_body) begin
            role = ROLE_BODY;
            pos  = POS_W'(r_body_cnt);
        end

        o_word.byte_out       = b;
        o_word.role           = role;
        o_word.field_position = pos;
        o_word.request_done   = i_word.end_of_request;
        o_word.method_length  = i_word.end_of_request ? 4'(n_method_cnt) : 4'd0;
        o_word.path_length    = i_word.end_of_request ? 8'(n_path_cnt) : 8'd0;
        o_word.body_length    = i_word.end_of_request ? 10'(n_body_cnt) : 10'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_word.end_of_request)) begin
            r_phase      <= PH_METHOD;
            r_method_cnt <= '0;
            r_path_cnt   <= '0;
            r_body_cnt   <= '0;
            r_match      <= MATCH_NONE;
            r_zero_seen  <= 1'b0;
            r_byte_cnt   <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_method_cnt <= n_method_cnt;
            r_path_cnt   <= n_path_cnt;
            r_body_cnt   <= n_body_cnt;
            r_match      <= n_match;
            r_zero_seen  <= n_zero_seen;
            r_byte_cnt   <= n_byte_cnt;
        end
    end

endmodule

// File: rtl/http_request_field_splitter_top.sv
// Flow: a word accepted into the input register is tagged into the result register,
// which drives o_out until the word is taken.
// Throughput: one word per cycle; o_out.ready low stalls the two-register pipeline.
// The parse state updates only when a word moves from the input register to the
// result register, so stalls never disturb the per-request counters.
// Reset: i_rst_n is synchronous and active low; it empties both registers and
// returns the parser to the start of a request.
module http_request_field_splitter_top import hrfs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrfs_in_if.sink     i_in,
    hrfs_out_if.source  o_out
);

    // Input register: holds the accepted word
    logic      r_s1_valid;
    t_in_word  r_s1_word;

    // Result register: holds the tagged word until taken
    logic      r_out_valid;
    t_out_word r_out_word;

    t_out_word tag_word;
    logic      adv_out;
    logic      adv_s1;
    logic      fire;

    // The result register can load when it is empty or being drained this cycle
    assign adv_out = !r_out_valid || o_out.ready;
    // The input register can load when empty or when its word moves on
    assign adv_s1  = !r_s1_valid || adv_out;
    // Commit the parse state exactly when a word moves into the result register
    assign fire    = r_s1_valid && adv_out;

    assign i_in.ready    = adv_s1;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_word;

    hrfs_tagger u_tagger (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (r_s1_word),
        .o_word  (tag_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_s1) begin
                r_s1_valid <= i_in.valid;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers: load on advance, no reset
    always_ff @(posedge i_clk) begin
        if (adv_s1 && i_in.valid) begin
            r_s1_word <= i_in.payload;
        end
        if (fire) begin
            r_out_word <= tag_word;
        end
    end

endmodule

// File: rtl/hrfs_checker.sv
module hrfs_checker import hrfs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input t_out_word  i_out_word
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("result word changed while stalled");

    // Untagged bytes carry no position
    a_none_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.role == ROLE_NONE |-> i_out_word.field_position == '0)
        else $error("untagged byte with nonzero position");

    // Lengths appear only on the final byte
    a_len_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_word.request_done |->
            i_out_word.method_length == '0 && i_out_word.path_length == '0 &&
            i_out_word.body_length == '0)
        else $error("lengths shown before end of request");

    // A method byte lies inside the method limit
    a_method_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.role == ROLE_METHOD |->
            i_out_word.field_position < POS_W'(METHOD_MAX))
        else $error("method position past limit");

    // With nothing accepted and output idle, no result appears without an accepted word
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && i_in_ready) ##1 !(i_in_valid && i_in_ready) && !i_out_valid
            |=> !i_out_valid || $past(i_out_valid, 2) || $past(i_in_valid && i_in_ready, 3))
        else $error("result without an accepted word");

endmodule

bind http_request_field_splitter_top hrfs_checker u_hrfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.payload)
);
